@@ rtl/core/tcw_pkg.sv @@
// Shared types and constants for the text console writer.
// No dependencies; imported by tcw_console_ctrl, text_console_writer, tcw_console_checker and the testbench top.
package tcw_pkg;

    localparam logic [7:0]  NEWLINE_GLYPH = 8'd10;
    localparam logic [15:0] SPACE_CELL    = 16'h0020;

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_READ   = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_FILL
    } t_state;

    typedef struct packed {
        t_opcode     opcode;
        logic [7:0]  glyph;
        logic [7:0]  attribute;
        logic [10:0] cell_index;
    } t_item;

    typedef struct packed {
        logic [15:0] cell_data;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_column;
    } t_result;

endpackage

@@ rtl/core/text_console_writer.sv @@
// Top level of the text console writer: stream ports, output register, cell store.
// Depends on tcw_pkg, tcw_cell_ram and tcw_console_ctrl.
//
//   Channel  Direction  Handshake                      Content
//   s_axis   in         s_axis_tvalid / s_axis_tready  one append or read transaction
//   m_axis   out        m_axis_tvalid / m_axis_tready  one result transaction per input
//
// After reset the block sweeps every cell of the store to spaces, one cell per cycle,
// and holds s_axis_tready low meanwhile.
// An append without scroll writes its cell in its accept cycle; a read passes through
// ST_READ because of the registered read port of the store. An append that scrolls copies
// rows 1 to ROWS-1 up one row through the store's single read and write port, one cell
// per cycle, then fills the last row.
// The result waits in a pending register and then in the output register, so a
// stalled m_axis side holds back at most one further transaction before the input stalls.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // glyph[7:0], attribute[15:8], cell_index[26:16], zero
    input  logic [0:0]  s_axis_tuser,   // opcode[0]: 0 append, 1 read
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // cell_data[15:0], cursor_row[20:16],
                                        // cursor_column[27:21], zero
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int AW = $clog2(CELL_COUNT);

    t_item         item;
    t_result       res;
    logic          res_valid;
    logic          res_ready;
    logic          we;
    logic          re;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [15:0]   wdata;
    logic [15:0]   rdata;

    t_result       r_out;
    logic          r_out_valid;

    // Unpack the input transaction.
    assign item = '{opcode: t_opcode'(s_axis_tuser[0]),
                    glyph: s_axis_tdata[7:0],
                    attribute: s_axis_tdata[15:8],
                    cell_index: s_axis_tdata[26:16]};

    tcw_console_ctrl #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_item     (item),
        .o_res_valid(res_valid),
        .i_res_ready(res_ready),
        .o_res      (res),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_re       (re),
        .o_raddr    (raddr),
        .i_rdata    (rdata)
    );

    tcw_cell_ram #(
        .DEPTH(CELL_COUNT),
        .AW   (AW)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_re   (re),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // The output register takes a new result whenever it is empty or being drained.
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.cursor_column, r_out.cursor_row, r_out.cell_data};

endmodule

@@ rtl/core/tcw_cell_ram.sv @@
// Cell store: one write port and one read port, read data registered.
// No dependencies; instantiated by text_console_writer.
module tcw_cell_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [15:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [15:0]   o_rdata
);

    logic [15:0] r_mem [DEPTH];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/tcw_console_ctrl.sv @@
// Console sequencer: cursor, clearing pass, item handling and the scroll copy/fill sweep.
// Depends on tcw_pkg; drives the ports of tcw_cell_ram.
module tcw_console_ctrl #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  tcw_pkg::t_item       i_item,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output tcw_pkg::t_result     o_res,
    output logic                 o_we,
    output logic [$clog2(ROWS*COLUMNS)-1:0] o_waddr,
    output logic [15:0]          o_wdata,
    output logic                 o_re,
    output logic [$clog2(ROWS*COLUMNS)-1:0] o_raddr,
    input  logic [15:0]          i_rdata
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int AW = $clog2(CELL_COUNT);
    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLUMNS);
    localparam logic [AW-1:0] LAST_CELL = AW'(CELL_COUNT - 1);
    localparam logic [AW-1:0] LAST_BASE = AW'((ROWS - 1) * COLUMNS);
    localparam logic [AW-1:0] ROW_LEN   = AW'(COLUMNS);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);

    t_state        r_state, n_state;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [AW-1:0] r_cur_addr, n_cur_addr;
    logic          r_res_valid, n_res_valid;
    logic          r_cp_pend, n_cp_pend;
    t_result       r_res, n_res;
    logic [7:0]    r_fill_attr, n_fill_attr;
    logic [AW-1:0] r_cp_wa, n_cp_wa;
    logic          r_hit, n_hit;

    logic          accept;
    logic          is_nl;
    logic          adv_row;
    logic          scroll;
    logic          finish;
    logic          idx_hit;
    logic [31:0]   idx_ext;
    logic [31:0]   nl_addr;
    logic [31:0]   row_ext;
    logic [31:0]   col_ext;

    assign o_ready  = (r_state == ST_IDLE) && !r_res_valid;
    assign accept   = i_valid && o_ready;
    assign is_nl    = (i_item.glyph == NEWLINE_GLYPH);
    assign adv_row  = is_nl || (r_col == LAST_COL);
    assign scroll   = adv_row && (r_row == LAST_ROW);
    assign idx_ext  = 32'(i_item.cell_index);
    assign idx_hit  = idx_ext < 32'(CELL_COUNT);
    assign nl_addr  = 32'(r_cur_addr) - 32'(r_col) + 32'(COLUMNS);
    assign finish   = (r_state == ST_FILL) && !r_cp_pend && (r_cnt == LAST_CELL);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_cnt == LAST_CELL) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_item.opcode == OP_READ) begin
                        n_state = ST_READ;
                    end else if (scroll) begin
                        n_state = ST_COPY;
                    end
                end
            end
            ST_READ: n_state = ST_IDLE;
            ST_COPY: begin
                if (r_cnt == LAST_CELL) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                if (finish) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        n_cnt       = r_cnt;
        n_row       = r_row;
        n_col       = r_col;
        n_cur_addr  = r_cur_addr;
        n_cp_pend   = 1'b0;
        n_cp_wa     = r_cp_wa;
        n_fill_attr = r_fill_attr;
        n_hit       = r_hit;
        n_res       = r_res;
        n_res_valid = r_res_valid && !i_res_ready;
        o_we        = 1'b0;
        o_waddr     = r_cnt;
        o_wdata     = SPACE_CELL;
        o_re        = 1'b0;
        o_raddr     = r_cnt;
        row_ext     = 32'(r_row);
        col_ext     = 32'(r_col);

        // A copied cell lands in the cycle after its read.
        if (r_cp_pend) begin
            o_we    = 1'b1;
            o_waddr = r_cp_wa;
            o_wdata = i_rdata;
        end

        unique case (r_state)
            ST_CLEAR: begin
                o_we  = 1'b1;
                n_cnt = r_cnt + AW'(1);
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_item.opcode == OP_READ) begin
                        o_re    = 1'b1;
                        o_raddr = idx_ext[AW-1:0];
                        n_hit   = idx_hit;
                    end else begin
                        if (!is_nl) begin
                            o_we    = 1'b1;
                            o_waddr = r_cur_addr;
                            o_wdata = {i_item.attribute, i_item.glyph};
                        end
                        if (scroll) begin
                            n_row       = LAST_ROW;
                            n_col       = '0;
                            n_cur_addr  = LAST_BASE;
                            n_fill_attr = i_item.attribute;
                            n_cnt       = ROW_LEN;
                        end else begin
                            if (adv_row) begin
                                n_row = r_row + RW'(1);
                                n_col = '0;
                            end else begin
                                n_col = r_col + CW'(1);
                            end
                            n_cur_addr = is_nl ? nl_addr[AW-1:0] : r_cur_addr + AW'(1);
                            row_ext     = 32'(n_row);
                            col_ext     = 32'(n_col);
                            n_res       = '{cell_data: '0, cursor_row: row_ext[4:0],
                                            cursor_column: col_ext[6:0]};
                            n_res_valid = 1'b1;
                        end
                    end
                end
            end
            ST_READ: begin
                n_res       = '{cell_data: r_hit ? i_rdata : 16'h0000,
                                cursor_row: row_ext[4:0], cursor_column: col_ext[6:0]};
                n_res_valid = 1'b1;
            end
            ST_COPY: begin
                o_re      = 1'b1;
                n_cp_pend = 1'b1;
                n_cp_wa   = r_cnt - ROW_LEN;
                n_cnt     = (r_cnt == LAST_CELL) ? LAST_BASE : r_cnt + AW'(1);
            end
            ST_FILL: begin
                if (!r_cp_pend) begin
                    o_we    = 1'b1;
                    o_waddr = r_cnt;
                    o_wdata = {r_fill_attr, 8'h00};
                    n_cnt   = r_cnt + AW'(1);
                    if (finish) begin
                        n_res       = '{cell_data: '0, cursor_row: row_ext[4:0],
                                        cursor_column: col_ext[6:0]};
                        n_res_valid = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_cur_addr  <= '0;
            r_res_valid <= 1'b0;
            r_cp_pend   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_row       <= n_row;
            r_col       <= n_col;
            r_cur_addr  <= n_cur_addr;
            r_res_valid <= n_res_valid;
            r_cp_pend   <= n_cp_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res       <= n_res;
        r_fill_attr <= n_fill_attr;
        r_cp_wa     <= n_cp_wa;
        r_hit       <= n_hit;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

`ifndef SYNTHESIS
    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_row) < 32'(ROWS)) && (32'(r_col) < 32'(COLUMNS)))
        else $error("cursor outside the screen");

    a_addr_tracks_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cur_addr) == 32'(r_row) * 32'(COLUMNS) + 32'(r_col))
        else $error("linear cursor address out of step with row and column");

    a_result_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> (r_state == ST_IDLE))
        else $error("result pending while a sweep is running");

    a_fill_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL && !r_cp_pend) |-> (r_cnt >= LAST_BASE))
        else $error("fill sweep outside the last row");
`endif

endmodule

@@ tb/sv/tcw_console_checker.sv @@
// Checker for the text console writer: watches both stream channels, predicts each result.
// Depends on tcw_pkg for the item, result and opcode types and the newline and space constants.
module tcw_console_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_in_data,    // glyph[7:0], attribute[15:8], cell_index[26:16], zero
    input  logic [0:0]  i_in_user,    // opcode[0]
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,   // cell_data[15:0], cursor_row[20:16],
                                      // cursor_column[27:21], zero
    output int          o_failures,
    output int          o_outstanding,
    output int          o_scrolls,
    output int          o_reads
);
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int CELL_COUNT  = COLUMNS * ROWS;
    localparam int MAX_REPORTS = 40;

    // Private copy of the screen and the cursor.
    logic [15:0] screen [CELL_COUNT];
    int unsigned cur_row;
    int unsigned cur_col;

    t_result     pending_results [$];
    int          failures;
    int          scroll_count;
    int          read_count;

    // Applies one transaction to the screen copy and returns the result it must produce.
    function automatic t_result console_step(t_item item);
        t_result res;
        res = '0;
        if (item.opcode == OP_APPEND) begin
            if (item.glyph == NEWLINE_GLYPH) begin
                cur_row++;
                cur_col = 0;
            end else begin
                screen[cur_row * COLUMNS + cur_col] = {item.attribute, item.glyph};
                cur_col++;
                if (cur_col >= COLUMNS) begin
                    cur_col = 0;
                    cur_row++;
                end
            end
            // Past the bottom: everything moves up one row and the new bottom row
            // takes the attribute of this transaction with a zero glyph.
            if (cur_row >= ROWS) begin
                for (int k = COLUMNS; k < CELL_COUNT; k++) begin
                    screen[k - COLUMNS] = screen[k];
                end
                for (int k = CELL_COUNT - COLUMNS; k < CELL_COUNT; k++) begin
                    screen[k] = {item.attribute, 8'h00};
                end
                cur_row = ROWS - 1;
                scroll_count++;
            end
        end else if (item.cell_index < CELL_COUNT) begin
            res.cell_data = screen[item.cell_index];
            read_count++;
        end
        res.cursor_row    = 5'(cur_row);
        res.cursor_column = 7'(cur_col);
        return res;
    endfunction

    function automatic void report_field(string field, int unsigned want, int unsigned got);
        failures++;
        if (failures <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_item   item;
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            for (int k = 0; k < CELL_COUNT; k++) begin
                screen[k] = SPACE_CELL;
            end
            cur_row = 0;
            cur_col = 0;
            pending_results.delete();
            failures     = 0;
            scroll_count = 0;
            read_count   = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    failures++;
                    if (failures <= MAX_REPORTS) begin
                        $display("%0t: result transaction 0x%0h with nothing expected",
                                 $time, i_out_data);
                    end
                end else begin
                    want = pending_results.pop_front();
                    got.cell_data     = i_out_data[15:0];
                    got.cursor_row    = i_out_data[20:16];
                    got.cursor_column = i_out_data[27:21];
                    if (got.cell_data !== want.cell_data) begin
                        report_field("cell_data", want.cell_data, got.cell_data);
                    end
                    if (got.cursor_row !== want.cursor_row) begin
                        report_field("cursor_row", want.cursor_row, got.cursor_row);
                    end
                    if (got.cursor_column !== want.cursor_column) begin
                        report_field("cursor_column", want.cursor_column, got.cursor_column);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                item.opcode     = t_opcode'(i_in_user[0]);
                item.glyph      = i_in_data[7:0];
                item.attribute  = i_in_data[15:8];
                item.cell_index = i_in_data[26:16];
                pending_results.push_back(console_step(item));
            end
        end
        o_failures    <= failures;
        o_outstanding <= pending_results.size();
        o_scrolls     <= scroll_count;
        o_reads       <= read_count;
    end

endmodule

@@ tb/sv/tb_text_console_writer.sv @@
// Top of the text console writer testbench: clock, reset, stimulus, receiver and verdict.
// Depends on tcw_pkg, the text_console_writer RTL and tcw_console_checker.
module tb_text_console_writer;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int COLUMNS         = 80;
    localparam int ROWS            = 25;
    localparam int CELL_COUNT      = COLUMNS * ROWS;
    localparam int ITEM_TARGET     = 1850;
    // Even if every append scrolled, with the pacing of both sides a correct run
    // stays under this limit.
    localparam int CYCLE_LIMIT     = 20_000_000;
    localparam int DRAIN_CYCLES    = 100;
    localparam int HOLD_OFF_AFTER  = 200;
    // Long enough to outlast two scrolls in a row, so the block always fills.
    localparam int HOLD_OFF_CYCLES = 6000;

    // Ways in which the receiver raises tready.
    typedef enum int unsigned {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_PERIODIC
    } t_ready_mode;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;    // glyph[7:0], attribute[15:8], cell_index[26:16], zero
    logic [0:0]  s_axis_tuser;    // opcode[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;    // cell_data[15:0], cursor_row[20:16],
                                  // cursor_column[27:21], zero

    int          failures;
    int          outstanding;
    int          scrolls;
    int          reads;
    int unsigned cycle_count  = 0;
    int unsigned results_seen = 0;
    int unsigned items_sent   = 0;
    int unsigned burst_left   = 0;
    logic        stim_done    = 1'b0;

    text_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // The checker sits beside the block and sees exactly the same handshakes.
    tcw_console_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_in_user     (s_axis_tuser),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .o_failures    (failures),
        .o_outstanding (outstanding),
        .o_scrolls     (scrolls),
        .o_reads       (reads)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (m_axis_tvalid && m_axis_tready) begin
            results_seen <= results_seen + 1;
        end
    end

    // Offers one transaction on the input channel. Transactions go out in bursts
    // of random length; between bursts tvalid drops for a random gap, sometimes none.
    // Inputs change only at the falling edge, so the block samples stable values.
    task automatic offer(input t_opcode op, input logic [7:0] glyph,
                         input logic [7:0] attr, input logic [10:0] index);
        if (burst_left == 0) begin
            s_axis_tvalid = 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12)) begin
                @(negedge i_clk);
            end
            // Now and then a long burst gives a stretch with no idling at all.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        s_axis_tdata  = {5'd0, index, attr, glyph};
        s_axis_tuser  = op;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        burst_left--;
        items_sent++;
    endtask

    // Stimulus: reset, a directed opening, then lines of random text with reads mixed in.
    initial begin
        int unsigned pick;
        int          line_len;
        logic [7:0]  line_attr;
        logic [7:0]  glyph;
        logic [7:0]  attr;
        logic [10:0] index;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Freshly cleared screen: first and last cell, then indexes past the end.
        offer(OP_READ,   8'hFF,         8'h00, 11'd0);
        offer(OP_READ,   8'h00,         8'hFF, 11'(CELL_COUNT - 1));
        offer(OP_READ,   8'h55,         8'hAA, 11'(CELL_COUNT));
        offer(OP_READ,   8'hAA,         8'h55, 11'h7FF);
        // Glyph and attribute extremes, then a newline mid-row and a blank line.
        offer(OP_APPEND, 8'h00,         8'h00, 11'h7FF);
        offer(OP_APPEND, 8'hFF,         8'hFF, 11'd0);
        offer(OP_APPEND, NEWLINE_GLYPH, 8'hA5, 11'h2AA);
        offer(OP_APPEND, NEWLINE_GLYPH, 8'h5A, 11'h555);
        // Control codes other than newline are stored like any other glyph.
        offer(OP_APPEND, 8'h09,         8'h1F, 11'd0);
        offer(OP_APPEND, 8'h0B,         8'h2E, 11'd0);
        offer(OP_APPEND, 8'h41,         8'h07, 11'd0);
        // Read back what was written and what the newlines skipped.
        offer(OP_READ,   8'h00,         8'h00, 11'd0);
        offer(OP_READ,   8'h00,         8'h00, 11'd1);
        offer(OP_READ,   8'h00,         8'h00, 11'd2);
        offer(OP_READ,   8'h00,         8'h00, 11'(COLUMNS));
        offer(OP_READ,   8'h00,         8'h00, 11'(2 * COLUMNS));
        offer(OP_READ,   8'h00,         8'h00, 11'(2 * COLUMNS + 2));
        offer(OP_READ,   8'h00,         8'h00, 11'(CELL_COUNT - COLUMNS));

        // Mostly short lines, so the cursor reaches the bottom soon and newlines
        // keep scrolling; a few lines run past the row end to exercise the wrap.
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                line_len = $urandom_range(0, 8);
            end else if (pick < 80) begin
                line_len = $urandom_range(9, 40);
            end else if (pick < 95) begin
                line_len = $urandom_range(41, 79);
            end else begin
                line_len = $urandom_range(80, 200);
            end
            line_attr = 8'($urandom_range(0, 255));
            for (int n = 0; n < line_len; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    // Reads favor the bottom rows, where recent text lands after scrolling.
                    pick = $urandom_range(0, 99);
                    if (pick < 35) begin
                        index = 11'($urandom_range(0, 2047));
                    end else if (pick < 75) begin
                        index = 11'($urandom_range(CELL_COUNT - 5 * COLUMNS, CELL_COUNT - 1));
                    end else begin
                        index = 11'($urandom_range(0, 4 * COLUMNS - 1));
                    end
                    offer(OP_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          index);
                end
                glyph = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(32, 126));
                attr  = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255)) : line_attr;
                offer(OP_APPEND, glyph, attr, 11'($urandom_range(0, 2047)));
            end
            // Most lines end in a newline; some run straight into the next one.
            if ($urandom_range(0, 9) != 0) begin
                offer(OP_APPEND, NEWLINE_GLYPH, 8'($urandom_range(0, 255)),
                      11'($urandom_range(0, 2047)));
            end
        end
        s_axis_tvalid = 1'b0;
        stim_done     = 1'b1;
    end

    // Receiver: tready follows a pattern that changes every so often. Once, after
    // enough results, it holds off for a long stretch while the sender keeps
    // offering, so the output register and the pending slot fill and tready drops.
    initial begin : receiver
        t_ready_mode mode;
        int unsigned span;
        bit          held;

        mode = RDY_ALWAYS;
        span = 0;
        held = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= HOLD_OFF_AFTER) begin
                held          = 1'b1;
                m_axis_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end
            if (span == 0) begin
                mode = t_ready_mode'($urandom_range(0, 3));
                span = $urandom_range(20, 200);
            end
            span--;
            case (mode)
                RDY_ALWAYS: begin
                    m_axis_tready = 1'b1;
                end
                RDY_COIN: begin
                    m_axis_tready = ($urandom_range(0, 1) == 1);
                end
                RDY_SPARSE: begin
                    m_axis_tready = ($urandom_range(0, 4) == 0);
                end
                default: begin
                    m_axis_tready = cycle_count[2];
                end
            endcase
        end
    end

    // Verdict: once all stimulus is in and every expected result has come, wait a
    // little longer for stray results, then report. The cycle limit guards hangs.
    initial begin
        do @(posedge i_clk);
        while (!(stim_done && outstanding == 0) && cycle_count < CYCLE_LIMIT);
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results still expected",
                     cycle_count, outstanding);
            $display("RESULT: ERROR");
        end else begin
            repeat (DRAIN_CYCLES) @(posedge i_clk);
            $display("Sent %0d transactions: %0d in-range reads, %0d scrolls, %0d results.",
                     items_sent, reads, scrolls, results_seen);
            $display("Included a %0d-cycle receiver hold-off and random bursts on both sides.",
                     HOLD_OFF_CYCLES);
            if (failures == 0 && outstanding == 0) begin
                $display("RESULT: OK");
            end else begin
                $display("RESULT: ERROR");
            end
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/tcw_pkg.sv
rtl/core/tcw_cell_ram.sv
rtl/core/tcw_console_ctrl.sv
rtl/core/text_console_writer.sv
tb/sv/tcw_console_checker.sv
tb/sv/tb_text_console_writer.sv
